// ===== hdl/hdac_pkg.sv =====
// ----------------------------------------------------------------------------
// hdac_pkg
// Shared types and constants of the halo dilation and alpha composite block.
// ----------------------------------------------------------------------------
package hdac_pkg;

    localparam int DEF_MAX_SIDE = 256;
    localparam int SIDE_W       = 9;
    localparam int CFG_W        = 24;
    localparam int PIX_W        = 8;
    localparam int NUM_W        = 26;
    localparam int D_W          = 16;
    localparam int QUO_BITS     = 8;
    localparam int ALPHA_BIAS   = 127;
    localparam int ALPHA_RECIP  = 32897;
    localparam int ALPHA_SHIFT  = 23;

    localparam logic [SIDE_W-1:0] RESET_SIDE = 9'd16;
    localparam logic [CFG_W-1:0]  RESET_FG   = 24'hFFFFFF;

    localparam logic [0:0] REG_SIDE = 1'b0;
    localparam logic [0:0] REG_FG   = 1'b1;

    localparam logic [1:0] OP_ALPHA = 2'd0;
    localparam logic [1:0] OP_RED   = 2'd1;
    localparam logic [1:0] OP_GREEN = 2'd2;
    localparam logic [1:0] OP_BLUE  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_MUL,
        ST_DLOAD,
        ST_DSTEP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       win;
        logic       mul;
        logic       dload;
        logic       dstep;
        logic       dlast;
        logic       out_load;
        logic [1:0] op;
    } t_cmd;

    typedef struct packed {
        logic have;
        logic out_busy;
    } t_stat;

endpackage

// ===== hdl/halo_dilate_alpha_composite.sv =====
// ----------------------------------------------------------------------------
// halo_dilate_alpha_composite
// 3x3 grayscale dilation of a coverage image with foreground-over-halo compositing.
//
// Input items (i_valid/o_ready) carry one coverage byte each, in raster order;
// after side*side pixels, send side+1 flush items to drain the window.
// Pixel q produces its result on input item q+side+1; items before that give
// no result. The last result carries o_last_pixel.
// Result items leave on o_valid/i_ready from an output register; the block
// takes the next input item while a result waits there.
// An item that yields no result passes only accept and window step. One with
// a result passes accept, window step, denominator, then three divisions on
// the one shared restoring divider (red, green, blue; alpha comes from a
// reciprocal multiply meanwhile), then the hand-off.
// If the receiver stalls, the hand-off waits until the output register frees.
// Configuration (i_cfg_valid, always ready): index 0 side, index 1 colour.
// Writing side starts a new image. Write only while the block is idle.
// Reset restores side 16 and white and clears position and window; the row
// stores need no clearing.
// ----------------------------------------------------------------------------
module halo_dilate_alpha_composite #(
    parameter int MAX_SIDE = hdac_pkg::DEF_MAX_SIDE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [0:0]                 i_cfg_index,
    input  logic [hdac_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [hdac_pkg::PIX_W-1:0] i_coverage,
    input  logic                       i_flush,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [hdac_pkg::PIX_W-1:0] o_alpha,
    output logic [hdac_pkg::PIX_W-1:0] o_red,
    output logic [hdac_pkg::PIX_W-1:0] o_green,
    output logic [hdac_pkg::PIX_W-1:0] o_blue,
    output logic                       o_last_pixel
);
    import hdac_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    hdac_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_cmd  (w_cmd),
        .i_stat (w_stat)
    );

    hdac_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_coverage  (i_coverage),
        .i_flush     (i_flush),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_alpha     (o_alpha),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_last_pixel(o_last_pixel)
    );

endmodule

// ===== hdl/hdac_ram.sv =====
// ----------------------------------------------------------------------------
// hdac_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hdac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/hdac_ctrl.sv =====
// ----------------------------------------------------------------------------
// hdac_ctrl
// Sequencer: window step, denominator, three shared divisions, result hand-off.
// ----------------------------------------------------------------------------
module hdac_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output hdac_pkg::t_cmd o_cmd,
    input  hdac_pkg::t_stat i_stat
);
    import hdac_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_bit, n_bit;
    logic [1:0] r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bit   <= '0;
            r_op    <= OP_ALPHA;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_WIN;
            ST_WIN:   n_state = i_stat.have ? ST_MUL : ST_IDLE;
            ST_MUL:   n_state = ST_DLOAD;
            ST_DLOAD: n_state = ST_DSTEP;
            ST_DSTEP: begin
                if (r_bit == 3'd0) begin
                    n_state = (r_op == OP_BLUE) ? ST_OUT : ST_DLOAD;
                end
            end
            ST_OUT:   if (!i_stat.out_busy) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_bit = r_bit;
        n_op  = r_op;
        unique case (r_state)
            ST_MUL:   n_op  = OP_RED;
            ST_DLOAD: n_bit = 3'(QUO_BITS - 1);
            ST_DSTEP: begin
                n_bit = r_bit - 3'd1;
                if (r_bit == 3'd0) n_op = r_op + 2'd1;
            end
            default: begin
                n_bit = r_bit;
                n_op  = r_op;
            end
        endcase
    end

    always_comb begin
        o_ready        = (r_state == ST_IDLE);
        o_cmd          = '0;
        o_cmd.op       = r_op;
        o_cmd.accept   = (r_state == ST_IDLE) && i_valid;
        o_cmd.win      = (r_state == ST_WIN);
        o_cmd.mul      = (r_state == ST_MUL);
        o_cmd.dload    = (r_state == ST_DLOAD);
        o_cmd.dstep    = (r_state == ST_DSTEP);
        o_cmd.dlast    = (r_state == ST_DSTEP) && (r_bit == 3'd0);
        o_cmd.out_load = (r_state == ST_OUT) && !i_stat.out_busy;
    end

`ifndef SYNTHESIS
    a_accept_to_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid) |=> (r_state == ST_WIN))
        else $error("accepted item did not start a window step");
    a_load_to_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DLOAD) |=> (r_state == ST_DSTEP && r_bit == 3'(QUO_BITS - 1)))
        else $error("division did not start at the top quotient bit");
    a_blue_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DSTEP && r_bit == 3'd0 && r_op == OP_BLUE) |=> (r_state == ST_OUT))
        else $error("last division did not lead to result hand-off");
`endif

endmodule

// ===== hdl/hdac_dp.sv =====
// ----------------------------------------------------------------------------
// hdac_dp
// Datapath: config registers, raster position, row stores, 3x3 window,
// denominator, alpha by reciprocal multiply and a restoring divider shared
// by the three color channels.
// ----------------------------------------------------------------------------
module hdac_dp #(
    parameter int MAX_SIDE = hdac_pkg::DEF_MAX_SIDE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [0:0]                  i_cfg_index,
    input  logic [hdac_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [hdac_pkg::PIX_W-1:0]  i_coverage,
    input  logic                        i_flush,
    input  hdac_pkg::t_cmd              i_cmd,
    output hdac_pkg::t_stat             o_stat,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hdac_pkg::PIX_W-1:0]  o_alpha,
    output logic [hdac_pkg::PIX_W-1:0]  o_red,
    output logic [hdac_pkg::PIX_W-1:0]  o_green,
    output logic [hdac_pkg::PIX_W-1:0]  o_blue,
    output logic                        o_last_pixel
);
    import hdac_pkg::*;

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int AW = $clog2(MAX_SIDE);
    localparam int RW = SW + 1;

    function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [SIDE_W-1:0] r_side;
    logic [CFG_W-1:0]  r_fg;
    logic [SW-1:0]     w_es;
    logic [RW-1:0]     w_es_w;
    logic [SW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [PIX_W-1:0]  r_cov;
    logic              r_flush;
    logic [PIX_W-1:0]  w_up_q, w_mid_q;
    logic [PIX_W-1:0]  w_top, w_mid, w_bot, w_cmax, w_dil;
    logic [PIX_W-1:0]  r_w0, r_w1, r_w3;
    logic [PIX_W-1:0]  r_dil, r_cen;
    logic              r_last;
    logic              w_have, w_at_end;
    logic [D_W-1:0]    r_d;
    logic [PIX_W-1:0]  w_chan;
    logic [15:0]       w_prod;
    logic [D_W-1:0]    w_alpha_sum;
    logic [31:0]       w_alpha_prod;
    logic [PIX_W-1:0]  w_alpha;
    logic [NUM_W-1:0]  r_rem, r_dv;
    logic [QUO_BITS-1:0] r_quo;
    logic [PIX_W-1:0]  r_res [4];
    logic              w_ge;
    logic              r_valid;
    logic              w_zero;

    always_comb begin
        if (r_side == '0) begin
            w_es = SW'(1);
        end else if (32'(r_side) > MAX_SIDE) begin
            w_es = SW'(MAX_SIDE);
        end else begin
            w_es = SW'(r_side);
        end
        w_es_w = {1'b0, w_es};
    end

    hdac_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_upper (
        .i_clk  (i_clk),
        .i_we   (i_cmd.win),
        .i_waddr(r_col[AW-1:0]),
        .i_wdata(w_mid_q),
        .i_raddr(r_col[AW-1:0]),
        .o_rdata(w_up_q)
    );

    hdac_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_middle (
        .i_clk  (i_clk),
        .i_we   (i_cmd.win),
        .i_waddr(r_col[AW-1:0]),
        .i_wdata(w_bot),
        .i_raddr(r_col[AW-1:0]),
        .o_rdata(w_mid_q)
    );

    always_comb begin
        w_top  = (r_row >= RW'(2) && r_row <= w_es_w + RW'(1)) ? w_up_q : '0;
        w_mid  = (r_row >= RW'(1) && r_row <= w_es_w) ? w_mid_q : '0;
        w_bot  = (r_row < w_es_w && !r_flush) ? r_cov : '0;
        w_cmax = max2(max2(w_top, w_mid), w_bot);
        if (r_col == '0) begin
            w_dil = max2(r_w0, (w_es >= SW'(2)) ? r_w1 : '0);
        end else begin
            w_dil = max2(max2(w_cmax, r_w0), (r_col >= SW'(2)) ? r_w1 : '0);
        end
        w_have   = (r_row >= RW'(2)) || (r_row == RW'(1) && r_col != '0);
        w_at_end = (r_row == w_es_w + RW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= RESET_SIDE;
            r_fg   <= RESET_FG;
            r_col  <= '0;
            r_row  <= '0;
            r_w0   <= '0;
            r_w1   <= '0;
            r_w3   <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_SIDE: begin
                        r_side <= i_cfg_data[SIDE_W-1:0];
                        r_col  <= '0;
                        r_row  <= '0;
                    end
                    REG_FG:   r_fg <= i_cfg_data;
                    default:  r_fg <= r_fg;
                endcase
            end else if (i_cmd.win) begin
                r_w1 <= r_w0;
                r_w0 <= w_cmax;
                r_w3 <= w_mid;
                if (w_at_end) begin
                    r_row <= '0;
                    r_col <= '0;
                end else if (r_col + SW'(1) == w_es) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= r_col + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cov   <= i_coverage;
            r_flush <= i_flush;
        end
        if (i_cmd.win) begin
            r_dil  <= w_dil;
            r_cen  <= r_w3;
            r_last <= w_at_end;
        end
        if (i_cmd.mul) begin
            r_d <= ({r_cen, 8'd0} - D_W'(r_cen))
                   + D_W'(r_dil) * (D_W'(8'd255) - D_W'(r_cen));
        end
    end

    always_comb begin
        case (i_cmd.op)
            OP_RED:   w_chan = r_fg[23:16];
            OP_GREEN: w_chan = r_fg[15:8];
            default:  w_chan = r_fg[7:0];
        endcase
        w_prod       = w_chan * r_cen;
        w_ge         = (r_rem >= r_dv);
        w_alpha_sum  = r_d + D_W'(ALPHA_BIAS);
        w_alpha_prod = 32'(w_alpha_sum) * 32'(ALPHA_RECIP);
        w_alpha      = w_alpha_prod[ALPHA_SHIFT +: PIX_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dload) begin
            r_quo <= '0;
            r_rem <= (NUM_W'(w_prod) << 9) - (NUM_W'(w_prod) << 1) + NUM_W'(r_d);
            r_dv  <= NUM_W'(r_d) << QUO_BITS;
            if (i_cmd.op == OP_RED) r_res[OP_ALPHA] <= w_alpha;
        end else if (i_cmd.dstep) begin
            if (w_ge) r_rem <= r_rem - r_dv;
            r_dv  <= r_dv >> 1;
            r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
            if (i_cmd.dlast) r_res[i_cmd.op] <= {r_quo[QUO_BITS-2:0], w_ge};
        end
    end

    assign w_zero = (r_d == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_alpha      <= w_zero ? '0 : r_res[OP_ALPHA];
            o_red        <= w_zero ? '0 : r_res[OP_RED];
            o_green      <= w_zero ? '0 : r_res[OP_GREEN];
            o_blue       <= w_zero ? '0 : r_res[OP_BLUE];
            o_last_pixel <= r_last;
        end
    end

    assign o_valid         = r_valid;
    assign o_stat.have     = w_have;
    assign o_stat.out_busy = r_valid && !i_ready;

endmodule
